/* rtl/decimal_integer_parser_macros.svh */
// Assertion macros for the decimal integer parser.
`ifndef DECIMAL_INTEGER_PARSER_MACROS_SVH
`define DECIMAL_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dip assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dip assertion failed");

`endif

/* rtl/dip_pkg.sv */
`timescale 1ns / 1ps

package dip_pkg;

    localparam int unsigned MagW   = 64;
    localparam int unsigned CountW = 5;
    localparam int unsigned ModeW  = 3;

    localparam logic [ModeW-1:0] MODE_INT64  = 3'd0;
    localparam logic [ModeW-1:0] MODE_INT32  = 3'd1;
    localparam logic [ModeW-1:0] MODE_INT16  = 3'd2;
    localparam logic [ModeW-1:0] MODE_UINT16 = 3'd3;
    localparam logic [ModeW-1:0] MODE_UINT8  = 3'd4;

    localparam logic [ModeW-1:0] MODE_RESET = MODE_INT32;

    localparam logic [CountW-1:0] MAX_DIGITS_WIDE   = 5'd19;
    localparam logic [CountW-1:0] MAX_DIGITS_NARROW = 5'd10;

    localparam logic [MagW-1:0] POS_LIMIT_64 = 64'd9223372036854775807;
    localparam logic [MagW-1:0] NEG_LIMIT_64 = 64'd9223372036854775808;
    localparam logic [MagW-1:0] POS_LIMIT_32 = 64'd2147483647;
    localparam logic [MagW-1:0] NEG_LIMIT_32 = 64'd2147483648;
    localparam logic [MagW-1:0] POS_LIMIT_16 = 64'd32767;
    localparam logic [MagW-1:0] NEG_LIMIT_16 = 64'd32768;
    localparam logic [MagW-1:0] LIMIT_U16    = 64'd65535;
    localparam logic [MagW-1:0] LIMIT_U8     = 64'd255;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

/* rtl/decimal_integer_parser.sv */
// Throughput: one character item per cycle; an end-of-string item waits while the
// output stalls. The digit step (mag * 10 + digit) is one registered stage, and the
// range check and sign feed the output register.
// Reset (i_rst_n low, synchronous): pipeline empty, parse state cleared, mode = int32.
`timescale 1ns / 1ps

`include "decimal_integer_parser_macros.svh"

module decimal_integer_parser
    import dip_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_char_code,
    input  logic                     i_char_valid,
    input  logic                     i_end_of_string,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [MagW-1:0]   o_parsed_value,
    output logic                     o_parse_ok,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [ModeW-1:0]         i_cfg_data
);

    logic [ModeW-1:0]  r_mode;

    logic              r_in_valid;
    logic [7:0]        r_in_code;
    logic              r_in_cvalid;
    logic              r_in_eos;

    logic              r_at_first, n_at_first;
    logic              r_neg, n_neg;
    logic [CountW-1:0] r_count, n_count;
    logic [MagW-1:0]   r_mag, n_mag;
    logic              r_failed, n_failed;

    logic              r_fin_valid;
    logic              r_fin_bad;
    logic              r_fin_neg;
    logic [CountW-1:0] r_fin_count;
    logic [MagW-1:0]   r_fin_mag;

    logic              r_out_valid;
    logic [MagW-1:0]   r_value;
    logic              r_ok;

    logic              out_free, adv_fin, fin_free, adv_in;
    logic              is_sign, is_digit;
    logic [3:0]        digit;
    logic [MagW-1:0]   mag_step;
    logic              in_range, count_ok, fin_ok;
    logic [MagW-1:0]   fin_value;

    // handshake chain
    assign out_free    = !r_out_valid || i_out_ready;
    assign adv_fin     = r_fin_valid && out_free;
    assign fin_free    = !r_fin_valid || adv_fin;
    assign adv_in      = r_in_valid && (!r_in_eos || fin_free);
    assign o_in_ready  = !r_in_valid || adv_in;
    assign o_cfg_ready = 1'b1;

    // digit step
    assign is_sign  = r_at_first && (r_in_code == CHAR_MINUS || r_in_code == CHAR_PLUS);
    assign is_digit = (r_in_code >= CHAR_ZERO) && (r_in_code <= CHAR_NINE);
    assign digit    = r_in_code[3:0];
    assign mag_step = {r_mag[MagW-4:0], 3'b000} + {r_mag[MagW-2:0], 1'b0}
                    + {{(MagW-4){1'b0}}, digit};

    always_comb begin
        n_at_first = r_at_first;
        n_neg      = r_neg;
        n_count    = r_count;
        n_mag      = r_mag;
        n_failed   = r_failed;
        if (r_in_cvalid) begin
            if (is_sign) begin
                n_neg = (r_in_code == CHAR_MINUS);
            end else if (!is_digit) begin
                n_failed = 1'b1;
            end else if (!r_failed) begin
                if (r_count >= MAX_DIGITS_WIDE) begin
                    n_failed = 1'b1;
                end else begin
                    n_mag   = mag_step;
                    n_count = r_count + 1'b1;
                end
            end
            n_at_first = 1'b0;
        end
    end

    // range check and sign
    always_comb begin
        in_range = 1'b1;
        if (r_mode == MODE_INT64) begin
            in_range = r_fin_neg ? (r_fin_mag <= NEG_LIMIT_64) : (r_fin_mag <= POS_LIMIT_64);
            count_ok = (r_fin_count <= MAX_DIGITS_WIDE);
        end else begin
            count_ok = (r_fin_count <= MAX_DIGITS_NARROW);
            if (r_fin_neg ? (r_fin_mag > NEG_LIMIT_32) : (r_fin_mag > POS_LIMIT_32)) begin
                in_range = 1'b0;
            end else begin
                unique case (r_mode)
                    MODE_INT16: begin
                        in_range = r_fin_neg ? (r_fin_mag <= NEG_LIMIT_16)
                                             : (r_fin_mag <= POS_LIMIT_16);
                    end
                    MODE_UINT16: begin
                        in_range = r_fin_neg ? (r_fin_mag == '0) : (r_fin_mag <= LIMIT_U16);
                    end
                    MODE_UINT8: begin
                        in_range = r_fin_neg ? (r_fin_mag == '0) : (r_fin_mag <= LIMIT_U8);
                    end
                    default: begin
                        in_range = 1'b1;
                    end
                endcase
            end
        end
    end

    assign fin_ok    = !r_fin_bad && count_ok && in_range;
    assign fin_value = !fin_ok ? '0 : (r_fin_neg ? ('0 - r_fin_mag) : r_fin_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_in_valid  <= 1'b0;
            r_at_first  <= 1'b1;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_mag       <= '0;
            r_failed    <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (adv_in) begin
                if (r_in_eos) begin
                    r_at_first <= 1'b1;
                    r_neg      <= 1'b0;
                    r_count    <= '0;
                    r_mag      <= '0;
                    r_failed   <= 1'b0;
                end else begin
                    r_at_first <= n_at_first;
                    r_neg      <= n_neg;
                    r_count    <= n_count;
                    r_mag      <= n_mag;
                    r_failed   <= n_failed;
                end
            end

            if (fin_free) begin
                r_fin_valid <= adv_in && r_in_eos;
            end

            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_code   <= i_char_code;
            r_in_cvalid <= i_char_valid;
            r_in_eos    <= i_end_of_string;
        end
        if (adv_in && r_in_eos) begin
            r_fin_bad   <= n_at_first || n_failed;
            r_fin_neg   <= n_neg;
            r_fin_count <= n_count;
            r_fin_mag   <= n_mag;
        end
        if (adv_fin) begin
            r_value <= fin_value;
            r_ok    <= fin_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_parse_ok     = r_ok;

    `DIP_ASSERT_NOW(a_fail_is_zero, r_out_valid && !r_ok, r_value == '0)
    `DIP_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_DIGITS_WIDE)
    `DIP_ASSERT_NEXT(a_clear_after_end, adv_in && r_in_eos, r_at_first && r_count == '0 && !r_failed)

endmodule
